// ===== hw/rtl/ordered_or_fifo_queue_core_assert.svh =====
// ----------------------------------------------------------------------------
// ordered_or_fifo_queue_core_assert.svh
// Assertion macros shared by the queue core.
// ----------------------------------------------------------------------------
`ifndef ORDERED_OR_FIFO_QUEUE_CORE_ASSERT_SVH
`define ORDERED_OR_FIFO_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define OOQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define OOQ_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ooq_pkg.sv =====
// ----------------------------------------------------------------------------
// ooq_pkg
// Shared types and codes of the ordered or FIFO queue core.
// ----------------------------------------------------------------------------
package ooq_pkg;

  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_PEEK   = 2'd1,
    OP_POP    = 2'd2,
    OP_DROP   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } rsp_code_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the request and compare it against every cell
    logic update;   // apply the operation and load the result register
  } ooq_cmd_t;

endpackage

// ===== hw/rtl/ooq_req_if.sv =====
// ----------------------------------------------------------------------------
// ooq_req_if
// Request channel: one queue operation per item.
// ----------------------------------------------------------------------------
interface ooq_req_if
  import ooq_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      op;
  logic [VALUE_W-1:0]   value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

// ===== hw/rtl/ooq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ooq_rsp_if
// Response channel: one result item per request.
// ----------------------------------------------------------------------------
interface ooq_rsp_if
  import ooq_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [VALUE_W-1:0]   head_value;
  logic [COUNT_W-1:0]   count;

  modport source (output valid, output status, output head_value, output count,
                  input ready);
  modport sink   (input valid, input status, input head_value, input count,
                  output ready);
endinterface

// ===== hw/rtl/ordered_or_fifo_queue_core.sv =====
// ----------------------------------------------------------------------------
// ordered_or_fifo_queue_core
// Bounded queue that keeps either arrival order or stable ascending order.
//
//   Channel  Direction  Handshake      Payload
//   req      in         valid / ready  op, value
//   rsp      out        valid / ready  status, head_value, count
//   cfg      in         cfg_we         cfg_wdata (ordered_mode)
//
// For each item, in the accept cycle every cell compares its entry with the
// incoming value and the compare result is registered; in the update state the
// whole row of cells shifts at once and the result register loads. The update waits
// while an earlier result is still held on rsp, so a stall on rsp stalls req.
// Reset is synchronous and leaves the queue empty in FIFO mode; a cfg write
// also empties the queue.
// ----------------------------------------------------------------------------
`include "ordered_or_fifo_queue_core_assert.svh"

module ordered_or_fifo_queue_core
  import ooq_pkg::*;
#(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  ooq_req_if.sink     req,
  ooq_rsp_if.source   rsp
);

  // The count field wraps at 32, so a full queue reports its capacity modulo 32.
  localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(CAPACITY);

  ooq_cmd_t cmd;

  // The controller sequences accept and update; it owns the result valid flag.
  ooq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  // The datapath holds the cells, the occupancy, the mode and the result payload.
  ooq_datapath #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .req_op         (req.op),
    .req_value      (req.value),
    .rsp_status     (rsp.status),
    .rsp_head_value (rsp.head_value),
    .rsp_count      (rsp.count)
  );

  // Only one item is in flight: after an accept the request side closes.
  `OOQ_ASSERT_NXT(a_one_in_flight, clk, rst, req.valid && req.ready, !req.ready, "second item accepted while one is in flight")

  // An update always presents a result in the following cycle.
  `OOQ_ASSERT_NXT(a_update_shows, clk, rst, cmd.update, rsp.valid, "update did not produce a result")

  // A full report carries the capacity as its count.
  `OOQ_ASSERT_NOW(a_full_count, clk, rst, rsp.valid && (rsp.status == ST_FULL), rsp.count == COUNT_FULL, "full status with wrong count")

  // An empty report carries a zero count and a zero head value.
  `OOQ_ASSERT_NOW(a_empty_count, clk, rst, rsp.valid && (rsp.status == ST_EMPTY), (rsp.count == '0) && (rsp.head_value == '0), "empty status with nonzero payload")

endmodule

// ===== hw/rtl/ooq_ctrl.sv =====
// ----------------------------------------------------------------------------
// ooq_ctrl
// Sequencer: accepts one request, then applies it once the result register
// is free.
// ----------------------------------------------------------------------------
module ooq_ctrl
  import ooq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output ooq_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_UPDATE = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_UPDATE;
        end
      end
      S_UPDATE: begin
        // The result register must be empty or draining this cycle.
        if (!out_valid || out_ready) begin
          cmd.update     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== hw/rtl/ooq_datapath.sv =====
// ----------------------------------------------------------------------------
// ooq_datapath
// Row of compare-and-shift cells holding the queue, plus the result register.
// ----------------------------------------------------------------------------
module ooq_datapath
  import ooq_pkg::*;
#(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ooq_cmd_t             cmd,
  input  logic                 cfg_we,
  input  logic                 cfg_wdata,
  input  logic [OP_W-1:0]      req_op,
  input  logic [VALUE_W-1:0]   req_value,
  output logic [STATUS_W-1:0]  rsp_status,
  output logic [VALUE_W-1:0]   rsp_head_value,
  output logic [COUNT_W-1:0]   rsp_count
);

  localparam int OCC_W = $clog2(CAPACITY + 1);
  localparam int LVLS  = $clog2(CAPACITY);

  logic [VALUE_WIDTH-1:0] entry      [CAPACITY];
  logic [VALUE_WIDTH-1:0] entry_next [CAPACITY];
  logic [OCC_W-1:0]       occ;
  logic                   mode;

  logic [OP_W-1:0]        op_q;
  logic [VALUE_WIDTH-1:0] val_q;
  logic [CAPACITY-1:0]    keep_q;   // cell stays in place on insert
  logic [CAPACITY-1:0]    rm_q;     // cell matches the removal; the lowest match goes
  logic [CAPACITY-1:0]    rm_pre;   // cell at or after the removed one

  logic [VALUE_WIDTH-1:0] val_in;
  logic [CAPACITY-1:0]    keep_in;
  logic [CAPACITY-1:0]    rm_in;

  logic                   is_empty;
  logic                   is_full;
  logic                   do_ins;
  logic                   do_rm;
  rsp_code_t              status_next;
  logic [VALUE_WIDTH-1:0] head_next;
  logic [OCC_W-1:0]       occ_next;

  assign val_in = VALUE_WIDTH'(req_value);

  // Per-cell compare against the incoming value.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cmp
    logic valid;
    assign valid      = OCC_W'(i) < occ;
    assign keep_in[i] = valid && (!mode || (entry[i] <= val_in));
    if (i == 0) begin : g_head
      assign rm_in[i] = (req_op == OP_POP) ? valid : (valid && (entry[i] == val_in));
    end else begin : g_body
      assign rm_in[i] = (req_op == OP_POP) ? 1'b0 : (valid && (entry[i] == val_in));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= req_op;
      val_q  <= val_in;
      keep_q <= keep_in;
      rm_q   <= rm_in;
    end
  end

  // Log-depth prefix OR marks every cell from the removed one onward.
  always_comb begin
    rm_pre = rm_q;
    for (int l = 0; l < LVLS; l++) begin
      rm_pre = rm_pre | (rm_pre << (1 << l));
    end
  end

  // Next value of each cell for insert and for removal.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] ins_val;
    logic [VALUE_WIDTH-1:0] rm_val;
    if (i == 0) begin : g_first
      assign ins_val = keep_q[i] ? entry[i] : val_q;
    end else begin : g_rest
      assign ins_val = keep_q[i] ? entry[i] : (keep_q[i-1] ? val_q : entry[i-1]);
    end
    if (i == CAPACITY - 1) begin : g_last
      assign rm_val = entry[i];
    end else begin : g_inner
      assign rm_val = rm_pre[i] ? entry[i+1] : entry[i];
    end
    assign entry_next[i] = do_ins ? ins_val : rm_val;
  end

  assign is_empty = (occ == '0);
  assign is_full  = (occ == OCC_W'(CAPACITY));

  always_comb begin
    status_next = ST_OK;
    head_next   = '0;
    do_ins      = 1'b0;
    do_rm       = 1'b0;
    occ_next    = occ;
    case (op_t'(op_q))
      OP_INSERT: begin
        if (is_full) begin
          status_next = ST_FULL;
        end else begin
          do_ins   = 1'b1;
          occ_next = occ + OCC_W'(1);
        end
      end
      OP_PEEK: begin
        if (is_empty) begin
          status_next = ST_EMPTY;
        end else begin
          head_next = entry[0];
        end
      end
      OP_POP: begin
        if (is_empty) begin
          status_next = ST_EMPTY;
        end else begin
          head_next = entry[0];
          do_rm     = 1'b1;
          occ_next  = occ - OCC_W'(1);
        end
      end
      OP_DROP: begin
        if (is_empty) begin
          status_next = ST_EMPTY;
        end else if (!(|rm_q)) begin
          status_next = ST_NOTFOUND;
        end else begin
          do_rm    = 1'b1;
          occ_next = occ - OCC_W'(1);
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.update && (do_ins || do_rm)) begin
      for (int i = 0; i < CAPACITY; i++) begin
        entry[i] <= entry_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ  <= '0;
      mode <= 1'b0;
    end else if (cfg_we) begin
      occ  <= '0;
      mode <= cfg_wdata;
    end else if (cmd.update) begin
      occ <= occ_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      rsp_status     <= status_next;
      rsp_head_value <= VALUE_W'(head_next);
      rsp_count      <= COUNT_W'(occ_next);
    end
  end

endmodule

// ===== verif/ordered_or_fifo_queue_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_or_fifo_queue_core_tb
// Self-checking bench for the ordered or FIFO queue core.
//
// A driver feeds queue operations from a backlog onto the request channel,
// and a monitor checks every result against a shadow copy of the queue kept
// in the bench. Both sides insert random idle cycles, and two long response
// stalls back the core up into its request side. The ordering mode is
// rewritten between phases, which also empties the queue.
// ----------------------------------------------------------------------------
module ordered_or_fifo_queue_core_tb;
  import ooq_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 210;
  localparam int HOLD_CYCLES = 64;

  typedef struct packed {
    op_t               op;
    logic [VALUE_W-1:0] value;
  } queue_req_t;

  typedef struct packed {
    rsp_code_t          status;
    logic [VALUE_W-1:0] head_value;
    logic [COUNT_W-1:0] count;
  } queue_rsp_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;

  ooq_req_if req_ch ();
  ooq_rsp_if rsp_ch ();

  ordered_or_fifo_queue_core #(
    .CAPACITY    (QUEUE_DEPTH),
    .VALUE_WIDTH (VALUE_W)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // Shadow of the queue contents, head first, and of the ordering mode.
  logic [VALUE_W-1:0] shadow_vals[$];
  bit                 shadow_ordered;

  // Operations waiting to be driven and results waiting to be seen.
  queue_req_t         req_backlog[$];
  queue_rsp_t         awaited_rsp[$];

  // Values inserted lately, so that removals by value often hit.
  logic [VALUE_W-1:0] recent_inserts[$];

  int items_queued;
  int items_sent;
  int results_seen;
  int error_count;
  int cfg_writes;
  int cycle_count;
  int status_tally[4];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Applies one operation to the shadow queue and returns the result that
  // the core must produce for it.
  function automatic queue_rsp_t predict_queue_op(op_t op, logic [VALUE_W-1:0] v);
    queue_rsp_t r;
    int         pos;
    bit         found;
    r.status     = ST_OK;
    r.head_value = '0;
    pos          = 0;
    found        = 1'b0;
    case (op)
      OP_INSERT: begin
        if (shadow_vals.size() >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
        end else if (shadow_ordered) begin
          // Go after every entry that is less than or equal, so equal
          // values stay in arrival order.
          while (pos < shadow_vals.size() && shadow_vals[pos] <= v) pos++;
          shadow_vals.insert(pos, v);
        end else begin
          shadow_vals.push_back(v);
        end
      end
      OP_PEEK: begin
        if (shadow_vals.size() == 0) r.status = ST_EMPTY;
        else r.head_value = shadow_vals[0];
      end
      OP_POP: begin
        if (shadow_vals.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.head_value = shadow_vals.pop_front();
        end
      end
      default: begin
        if (shadow_vals.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          while (!found && pos < shadow_vals.size()) begin
            if (shadow_vals[pos] == v) begin
              shadow_vals.delete(pos);
              found = 1'b1;
            end else begin
              pos++;
            end
          end
          r.status = found ? ST_OK : ST_NOTFOUND;
        end
      end
    endcase
    r.count = COUNT_W'(shadow_vals.size());
    return r;
  endfunction

  // Values lean toward the extremes and a small range, so that duplicates
  // and boundary comparisons turn up often.
  function automatic logic [VALUE_W-1:0] draw_value();
    logic [VALUE_W-1:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = '1;
      2, 3, 4: v = $urandom_range(0, 7);
      5, 6: begin
        if (recent_inserts.size() > 0)
          v = recent_inserts[$urandom_range(0, recent_inserts.size() - 1)];
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic add_req(op_t op, logic [VALUE_W-1:0] v);
    queue_req_t item;
    item.op    = op;
    item.value = v;
    req_backlog.push_back(item);
    items_queued++;
    if (op == OP_INSERT) begin
      recent_inserts.push_back(v);
      if (recent_inserts.size() > 24) void'(recent_inserts.pop_front());
    end
  endtask

  // Blocks until every queued operation has come back as a result, then lets the core settle.
  task automatic wait_drained();
    while (results_seen != items_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // The mode register is only written while the core is idle. The write
  // also empties the queue, so the shadow is cleared with it.
  task automatic write_mode(bit mode);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we    <= 1'b0;
    shadow_ordered = mode;
    shadow_vals.delete();
    cfg_writes++;
    repeat (2) @(posedge clk);
  endtask

  // Random operations in chunks whose insert share swings between light and
  // heavy, so the queue keeps running into full and into empty. Each phase
  // opens with a heavy fill.
  task automatic random_phase(int n_items);
    int ins_pct;
    ins_pct = 85;
    for (int k = 0; k < n_items; k++) begin
      if (k % 30 == 0 && k != 0) begin
        case ($urandom_range(0, 2))
          0: ins_pct = 15;
          1: ins_pct = 50;
          default: ins_pct = 85;
        endcase
      end
      if ($urandom_range(0, 99) < ins_pct) begin
        add_req(OP_INSERT, draw_value());
      end else begin
        case ($urandom_range(0, 2))
          0: add_req(OP_PEEK, $urandom);
          1: add_req(OP_POP, $urandom);
          default: begin
            if (recent_inserts.size() > 0 && $urandom_range(0, 9) < 7)
              add_req(OP_DROP, recent_inserts[$urandom_range(0, recent_inserts.size() - 1)]);
            else
              add_req(OP_DROP, draw_value());
          end
        endcase
      end
    end
  endtask

  // Driver: predicts each accepted item, then offers the next one from the
  // backlog after its drawn number of idle cycles.
  int         send_gap;
  bit         send_burst;
  queue_req_t next_req;

  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      send_gap   = 0;
      send_burst = 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        awaited_rsp.push_back(predict_queue_op(op_t'(req_ch.op), req_ch.value));
        items_sent++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          req_ch.valid <= 1'b0;
        end else if (req_backlog.size() > 0) begin
          next_req = req_backlog.pop_front();
          req_ch.valid <= 1'b1;
          req_ch.op    <= next_req.op;
          req_ch.value <= next_req.value;
          // Stretches without idling come and go at random.
          if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
          send_gap = send_burst ? 0 : $urandom_range(0, 3);
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result against the oldest prediction and
  // stalls the response side at random. Twice in the run it holds ready low
  // for a long stretch, so the core fills and stalls its request side while
  // the driver keeps offering.
  int         stall_left;
  int         hold_left;
  bit         recv_burst;
  queue_rsp_t want;

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
      recv_burst = 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        results_seen++;
        if (awaited_rsp.size() == 0) begin
          $error("result with no pending item: status %0d head_value %h count %0d",
                 rsp_ch.status, rsp_ch.head_value, rsp_ch.count);
          error_count++;
        end else begin
          want = awaited_rsp.pop_front();
          status_tally[want.status]++;
          if (rsp_ch.status !== want.status) begin
            $error("status: expected %s, actual %0d", want.status.name(), rsp_ch.status);
            error_count++;
          end
          if (rsp_ch.head_value !== want.head_value) begin
            $error("head_value: expected %h, actual %h", want.head_value, rsp_ch.head_value);
            error_count++;
          end
          if (rsp_ch.count !== want.count) begin
            $error("count: expected %0d, actual %0d", want.count, rsp_ch.count);
            error_count++;
          end
        end
        if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
        stall_left = recv_burst ? 0 : $urandom_range(0, 3);
        if (results_seen == 150 || results_seen == 1100) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: a run that has not ended by the cycle limit has hung.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding",
             cycle_count, items_queued - results_seen);
    $display("Test completed with failures");
    $finish;
  end

  // Stimulus sequence: directed checks in both modes, then random phases
  // with the mode rewritten between them.
  initial begin
    clk          = 1'b0;
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_wdata    = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.op    = OP_INSERT;
    req_ch.value = '0;
    rsp_ch.ready = 1'b0;
    shadow_ordered = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // FIFO mode: every operation on an empty queue, the value extremes,
    // a duplicate, a removal that misses and one that hits.
    write_mode(1'b0);
    add_req(OP_PEEK, '1);
    add_req(OP_POP, '0);
    add_req(OP_DROP, 32'h0000_0005);
    add_req(OP_INSERT, 32'hFFFF_FFFF);
    add_req(OP_INSERT, 32'h0000_0000);
    add_req(OP_INSERT, 32'h0000_0005);
    add_req(OP_INSERT, 32'h0000_0005);
    add_req(OP_PEEK, '0);
    add_req(OP_DROP, 32'h0000_0007);
    add_req(OP_DROP, 32'h0000_0005);
    add_req(OP_POP, '0);
    wait_drained();

    // Switching to ordered mode with entries still stored empties the queue.
    write_mode(1'b1);
    add_req(OP_PEEK, '0);
    add_req(OP_INSERT, 32'h0000_0009);
    add_req(OP_INSERT, 32'h0000_0003);
    add_req(OP_INSERT, 32'hFFFF_FFFF);
    add_req(OP_INSERT, 32'h0000_0000);
    add_req(OP_INSERT, 32'h0000_0003);
    add_req(OP_POP, '1);
    add_req(OP_DROP, 32'h0000_0003);
    add_req(OP_PEEK, '1);
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      random_phase(PHASE_ITEMS);
      wait_drained();
      case (p)
        0, 2, 5: write_mode(1'b0);
        default: write_mode(1'b1);
      endcase
    end

    // Nothing further should appear once the last result is in.
    repeat (16) @(posedge clk);
    if (awaited_rsp.size() != 0) begin
      $error("%0d expected results never arrived", awaited_rsp.size());
      error_count++;
    end

    $display("Covered %0d queue operations and %0d checked results across %0d mode writes.",
             items_sent, results_seen, cfg_writes);
    $display("Result mix: ok %0d, empty %0d, not found %0d, full %0d.",
             status_tally[ST_OK], status_tally[ST_EMPTY],
             status_tally[ST_NOTFOUND], status_tally[ST_FULL]);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
